### hw/rtl/segment_segment_intersect_core_defines.svh
// ----------------------------------------------------------------------------
// Segment intersection core: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_INTERSECT_CORE_DEFINES_SVH
`define SEGMENT_SEGMENT_INTERSECT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment intersect assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment intersect assertion failed");

`endif

### hw/rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, transaction types and pipeline types shared by the core.
// ----------------------------------------------------------------------------
package ssi_pkg;

   // Coordinate and arithmetic widths.
   localparam int SSI_COORD_WIDTH     = 16;
   localparam int SSI_PARAM_FRAC_BITS = 16;
   localparam int SSI_DIFF_WIDTH      = SSI_COORD_WIDTH + 1;
   localparam int SSI_PROD_WIDTH      = 2 * SSI_DIFF_WIDTH;
   localparam int SSI_CROSS_WIDTH     = SSI_PROD_WIDTH + 1;
   // Quotient bits kept before saturation to 32 bits.
   localparam int SSI_QUO_WIDTH       = 33;
   localparam int SSI_REM_WIDTH       = SSI_CROSS_WIDTH + SSI_QUO_WIDTH + 1;
   localparam int SSI_PARAM_WIDTH     = 32;

   // Input transaction.
   typedef struct packed {
      logic signed [SSI_COORD_WIDTH-1:0] first_start_x;
      logic signed [SSI_COORD_WIDTH-1:0] first_start_y;
      logic signed [SSI_COORD_WIDTH-1:0] first_end_x;
      logic signed [SSI_COORD_WIDTH-1:0] first_end_y;
      logic signed [SSI_COORD_WIDTH-1:0] second_start_x;
      logic signed [SSI_COORD_WIDTH-1:0] second_start_y;
      logic signed [SSI_COORD_WIDTH-1:0] second_end_x;
      logic signed [SSI_COORD_WIDTH-1:0] second_end_y;
   } ssi_req_type;

   // Result transaction.
   typedef struct packed {
      logic                              hit;
      logic                              parallel;
      logic signed [SSI_PARAM_WIDTH-1:0] first_param;
      logic signed [SSI_PARAM_WIDTH-1:0] second_param;
   } ssi_rsp_type;

   // One division lane: partial remainder and quotient bits found so far.
   typedef struct packed {
      logic [SSI_REM_WIDTH-1:0] rem;
      logic [SSI_QUO_WIDTH-1:0] quo;
   } ssi_lane_type;

   // Everything that travels through the divider stages.
   typedef struct packed {
      logic                       valid;
      logic                       parallel;
      logic                       hit;
      logic                       t_neg;
      logic                       t_ovf;
      logic                       u_neg;
      logic                       u_ovf;
      logic [SSI_CROSS_WIDTH-1:0] d_mag;
      ssi_lane_type               t;
      ssi_lane_type               u;
   } ssi_div_type;

endpackage

### hw/rtl/ssi_cross.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Forms the direction vectors, the three cross products, their magnitudes,
// the exact range test and the setup for the two quotient dividers.
// ----------------------------------------------------------------------------
module ssi_cross import ssi_pkg::*; #(
   parameter int PARAM_FRAC_BITS = SSI_PARAM_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  ssi_req_type in_data,
   output ssi_div_type out_data
);

   localparam int DW = SSI_DIFF_WIDTH;
   localparam int MW = SSI_PROD_WIDTH;
   localparam int PW = SSI_CROSS_WIDTH;
   localparam int RW = SSI_REM_WIDTH;

   // Stage 1: direction and offset vectors.
   logic                 v1_ff;
   logic signed [DW-1:0] rx_ff, ry_ff, sx_ff, sy_ff, wx_ff, wy_ff;

   function automatic logic signed [DW-1:0] diff(input logic [SSI_COORD_WIDTH-1:0] a,
                                                 input logic [SSI_COORD_WIDTH-1:0] b);
      diff = $signed({a[SSI_COORD_WIDTH-1], a}) - $signed({b[SSI_COORD_WIDTH-1], b});
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      rx_ff <= diff(in_data.first_end_x, in_data.first_start_x);
      ry_ff <= diff(in_data.first_end_y, in_data.first_start_y);
      sx_ff <= diff(in_data.second_end_x, in_data.second_start_x);
      sy_ff <= diff(in_data.second_end_y, in_data.second_start_y);
      wx_ff <= diff(in_data.second_start_x, in_data.first_start_x);
      wy_ff <= diff(in_data.second_start_y, in_data.first_start_y);
   end

   // Stage 2: the six products.
   logic                 v2_ff;
   logic signed [MW-1:0] dp_ff, dn_ff, tp_ff, tn_ff, up_ff, un_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      dp_ff <= rx_ff * sy_ff;
      dn_ff <= ry_ff * sx_ff;
      tp_ff <= wx_ff * sy_ff;
      tn_ff <= wy_ff * sx_ff;
      up_ff <= wx_ff * ry_ff;
      un_ff <= wy_ff * rx_ff;
   end

   // Stage 3: cross products.
   logic                 v3_ff;
   logic signed [PW-1:0] den_ff, tnum_ff, unum_ff;

   function automatic logic signed [PW-1:0] sub(input logic [MW-1:0] a,
                                                input logic [MW-1:0] b);
      sub = $signed({a[MW-1], a}) - $signed({b[MW-1], b});
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      den_ff  <= sub(dp_ff, dn_ff);
      tnum_ff <= sub(tp_ff, tn_ff);
      unum_ff <= sub(up_ff, un_ff);
   end

   // Stage 4: signs, magnitudes and zero tests.
   logic          v4_ff;
   logic          d_neg_ff, t_neg_ff, u_neg_ff;
   logic          d_zero_ff, t_zero_ff, u_zero_ff;
   logic [PW-1:0] d_mag_ff, t_mag_ff, u_mag_ff;

   function automatic logic [PW-1:0] mag(input logic [PW-1:0] a);
      mag = a[PW-1] ? (~a + PW'(1)) : a;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      d_neg_ff  <= den_ff[PW-1];
      t_neg_ff  <= tnum_ff[PW-1];
      u_neg_ff  <= unum_ff[PW-1];
      d_zero_ff <= (den_ff == '0);
      t_zero_ff <= (tnum_ff == '0);
      u_zero_ff <= (unum_ff == '0);
      d_mag_ff  <= mag(den_ff);
      t_mag_ff  <= mag(tnum_ff);
      u_mag_ff  <= mag(unum_ff);
   end

   // Stage 5: range test, overflow check and divider setup.
   logic [RW-1:0] t_shift, u_shift, d_top;
   logic          t_in_range, u_in_range;
   ssi_div_type   out_in;
   ssi_div_type   out_ff;

   always_comb begin
      t_shift    = RW'(t_mag_ff) << PARAM_FRAC_BITS;
      u_shift    = RW'(u_mag_ff) << PARAM_FRAC_BITS;
      d_top      = RW'(d_mag_ff) << SSI_QUO_WIDTH;
      t_in_range = t_zero_ff || ((t_neg_ff == d_neg_ff) && (t_mag_ff <= d_mag_ff));
      u_in_range = u_zero_ff || ((u_neg_ff == d_neg_ff) && (u_mag_ff <= d_mag_ff));
      out_in.valid    = v4_ff;
      out_in.parallel = d_zero_ff;
      out_in.hit      = !d_zero_ff && t_in_range && u_in_range;
      out_in.t_neg    = t_neg_ff ^ d_neg_ff;
      out_in.u_neg    = u_neg_ff ^ d_neg_ff;
      out_in.t_ovf    = (t_shift >= d_top);
      out_in.u_ovf    = (u_shift >= d_top);
      out_in.d_mag    = d_mag_ff;
      out_in.t.rem    = t_shift;
      out_in.t.quo    = '0;
      out_in.u.rem    = u_shift;
      out_in.u.quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.parallel <= out_in.parallel;
      out_ff.hit      <= out_in.hit;
      out_ff.t_neg    <= out_in.t_neg;
      out_ff.u_neg    <= out_in.u_neg;
      out_ff.t_ovf    <= out_in.t_ovf;
      out_ff.u_ovf    <= out_in.u_ovf;
      out_ff.d_mag    <= out_in.d_mag;
      out_ff.t        <= out_in.t;
      out_ff.u        <= out_in.u;
   end

   assign out_data = out_ff;

endmodule

### hw/rtl/ssi_div_stage.sv
// ----------------------------------------------------------------------------
// Segment intersection divider stage
// Decides one quotient bit of both parameter quotients by compare and
// subtract against the shifted denominator magnitude.
// ----------------------------------------------------------------------------
module ssi_div_stage import ssi_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  ssi_div_type in_data,
   output ssi_div_type out_data
);

   localparam int RW = SSI_REM_WIDTH;

   logic [RW-1:0] d_shift;
   ssi_div_type   out_in;
   ssi_div_type   out_ff;

   // Restoring step on both lanes.
   always_comb begin
      d_shift = RW'(in_data.d_mag) << BIT;
      out_in  = in_data;
      if (in_data.t.rem >= d_shift) begin
         out_in.t.rem      = in_data.t.rem - d_shift;
         out_in.t.quo[BIT] = 1'b1;
      end
      if (in_data.u.rem >= d_shift) begin
         out_in.u.rem      = in_data.u.rem - d_shift;
         out_in.u.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.parallel <= out_in.parallel;
      out_ff.hit      <= out_in.hit;
      out_ff.t_neg    <= out_in.t_neg;
      out_ff.u_neg    <= out_in.u_neg;
      out_ff.t_ovf    <= out_in.t_ovf;
      out_ff.u_ovf    <= out_in.u_ovf;
      out_ff.d_mag    <= out_in.d_mag;
      out_ff.t        <= out_in.t;
      out_ff.u        <= out_in.u;
   end

   assign out_data = out_ff;

endmodule

### hw/rtl/segment_segment_intersect_core.sv
// ----------------------------------------------------------------------------
// Segment segment intersection core
// Cross product intersection test of two 2D segments with Q16.16 parameters.
// ----------------------------------------------------------------------------
// The core accepts one segment pair in every clock cycle (busy stays low) and
// returns its result on rsp_data, marked by a one-cycle rsp_valid strobe; the
// receiver cannot stall the core, so results must be captured when they
// appear. The pipeline holds five front stages (differences, multipliers,
// cross products, magnitudes, range and overflow setup), one restoring
// divider stage per quotient bit (33 stages) and one saturation stage.
// Results leave in the order the transactions were accepted.
module segment_segment_intersect_core import ssi_pkg::*; #(
   parameter int PARAM_FRAC_BITS = SSI_PARAM_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ssi_req_type req_data,
   output logic        rsp_valid,
   output ssi_rsp_type rsp_data
);

`include "segment_segment_intersect_core_defines.svh"

   localparam int QW = SSI_QUO_WIDTH;
   localparam int OW = SSI_PARAM_WIDTH;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // Front end.
   ssi_div_type chain [QW+1];

   ssi_cross #(
      .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
   ) u_cross (
      .clock   (clock),
      .reset   (reset),
      .in_valid(start && !busy),
      .in_data (req_data),
      .out_data(chain[0])
   );

   // Divider stages, most significant quotient bit first.
   for (genvar g = 0; g < QW; g++) begin : g_div
      ssi_div_stage #(
         .BIT(QW - 1 - g)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .in_data (chain[g]),
         .out_data(chain[g+1])
      );
   end

   // Saturation to the signed parameter width.
   function automatic logic [OW-1:0] saturate(input logic neg, input logic ovf,
                                              input logic [QW-1:0] quo);
      logic [QW-1:0] max_pos;
      logic [QW-1:0] max_neg;
      max_pos = QW'({1'b0, {(OW-1){1'b1}}});
      max_neg = QW'({1'b1, {(OW-1){1'b0}}});
      if (neg) begin
         if (ovf || (quo > max_neg)) begin
            saturate = {1'b1, {(OW-1){1'b0}}};
         end else begin
            saturate = ~quo[OW-1:0] + OW'(1);
         end
      end else begin
         if (ovf || (quo > max_pos)) begin
            saturate = {1'b0, {(OW-1){1'b1}}};
         end else begin
            saturate = quo[OW-1:0];
         end
      end
   endfunction

   // Output register.
   ssi_div_type last;
   ssi_rsp_type rsp_in;
   ssi_rsp_type rsp_ff;
   logic        rsp_valid_ff;

   assign last = chain[QW];

   always_comb begin
      rsp_in.hit      = last.hit;
      rsp_in.parallel = last.parallel;
      if (last.parallel) begin
         rsp_in.first_param  = '0;
         rsp_in.second_param = '0;
      end else begin
         rsp_in.first_param  = saturate(last.t_neg, last.t_ovf, last.t.quo);
         rsp_in.second_param = saturate(last.u_neg, last.u_ovf, last.u.quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A parallel pair never hits and reports zero parameters.
   `SSI_ASSERT_SAME(a_parallel_zero, clock, reset, rsp_valid && rsp_data.parallel, !rsp_data.hit && (rsp_data.first_param == '0) && (rsp_data.second_param == '0))
   // A hit lies within zero and one on both segments; the upper bound is checked on the first only.
   `SSI_ASSERT_SAME(a_hit_range, clock, reset, rsp_valid && rsp_data.hit, !rsp_data.parallel && !rsp_data.first_param[OW-1] && !rsp_data.second_param[OW-1] && (rsp_data.first_param <= (OW'(1) << PARAM_FRAC_BITS)))
   // The last divider stage feeds the result strobe in the next cycle.
   `SSI_ASSERT_NEXT(a_strobe_follows, clock, reset, last.valid, rsp_valid)

endmodule
